// ===== design/dgpm_pkg.sv =====
// ----------------------------------------------------------------------------
// dgpm_pkg - shared types and constants of the delta-gamma pattern matcher
// Command and result records, status and register codes, queue depths.
// ----------------------------------------------------------------------------
package dgpm_pkg;

	// Defaults of the top-level parameters
	localparam int MAX_PATTERN_DEF   = 16;
	localparam int SYMBOL_BITS_DEF   = 8;
	localparam int POSITION_BITS_DEF = 16;

	// Queue depths (powers of two)
	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 4;

	// Fixed field widths
	localparam int SYM_IN_W   = 8;
	localparam int START_W    = 16;
	localparam int SUM_W      = 12;
	localparam int DELTA_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_TEXT = 1'b1
	} cmd_kind_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_PATTERN = 2'd1,
		ST_TOO_LONG   = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELTA    = 2'd0,
		REG_GAMMA    = 2'd1,
		REG_GAMMA_EN = 2'd2
	} cfg_reg_t;

	// One classified input beat
	typedef struct packed {
		cmd_kind_t             kind;
		logic [SYM_IN_W-1:0]   sym;
		logic                  last;
	} cmd_t;

	// One result beat
	typedef struct packed {
		logic                  found;
		logic [START_W-1:0]    start;
		logic [SUM_W-1:0]      sum;
		logic                  none;
		status_t               status;
	} result_t;

	// Register write
	typedef struct packed {
		logic                  wr_en;
		cfg_reg_t              index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

endpackage

// ===== design/dgpm_front.sv =====
// ----------------------------------------------------------------------------
// dgpm_front - input side of the pattern matcher
// Accepts input beats, tags them as pattern load or text, and holds them in
// a short command queue that the execution side drains.
// ----------------------------------------------------------------------------
module dgpm_front import dgpm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                cmd,
	input  logic [SYM_IN_W-1:0] symbol_value,
	input  logic                last,
	output logic                full,
	input  logic                deq,
	output logic                avail,
	output cmd_t                head
);

	localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CW = $clog2(CMD_DEPTH + 1);

	cmd_t           mem_q [CMD_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           push_ok;
	logic           pop_ok;
	cmd_t           cls;

	// Classify the incoming beat
	always_comb begin
		cls.kind = cmd ? CMD_TEXT : CMD_LOAD;
		cls.sym  = symbol_value;
		cls.last = last;
	end

	assign full    = (cnt_q == CW'(CMD_DEPTH));
	assign avail   = (cnt_q != '0);
	assign push_ok = push && !full;
	assign pop_ok  = deq && avail;
	assign head    = mem_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== design/dgpm_back.sv =====
// ----------------------------------------------------------------------------
// dgpm_back - execution side of the pattern matcher
// Stage 1 updates pattern and text shift lines and registers per-lane
// differences; stage 2 sums them in a tree, applies the limits and emits
// the result beat into the result queue.
// ----------------------------------------------------------------------------
module dgpm_back import dgpm_pkg::*; #(
	parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
	parameter int SYMBOL_BITS   = SYMBOL_BITS_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cfg_wr_t                          cfg_wr,
	input  logic                             cmd_avail,
	input  cmd_t                             cmd_head,
	output logic                             cmd_deq,
	input  logic [$clog2(RES_DEPTH+1)-1:0]   res_count,
	output logic                             res_push,
	output result_t                          res_data
);

	localparam int LW   = $clog2(MAX_PATTERN + 1);
	localparam int SB   = SYMBOL_BITS;
	localparam int PB   = POSITION_BITS;
	localparam int NL   = 1 << $clog2(MAX_PATTERN);
	localparam int SUMW = SB + $clog2(MAX_PATTERN);
	localparam int DW   = (SB > DELTA_W) ? SB : DELTA_W;
	localparam int GW   = (SUMW > SUM_W) ? SUMW : SUM_W;
	localparam int CW   = $clog2(RES_DEPTH + 1);
	localparam int SW   = (PB < START_W) ? PB : START_W;

	// Configuration
	logic [DELTA_W-1:0] delta_q;
	logic [SUM_W-1:0]   gamma_q;
	logic               gamma_en_q;

	// Pattern line: lane j holds pattern symbol plen-1-j
	logic [SB-1:0]      pat_q [MAX_PATTERN];
	// Text window: lane 0 holds the newest text symbol
	logic [SB-1:0]      win_q [MAX_PATTERN];
	logic [LW-1:0]      plen_q;
	logic               ready_q;
	logic [PB-1:0]      tpos_q;
	logic [LW-1:0]      fill_q;
	logic               any_q;

	// Stage 1 registers
	logic               valid_s1;
	logic               load_s1;
	logic               text_s1;
	status_t            status_s1;
	logic               check_s1;
	logic               dok_s1;
	logic               last_s1;
	logic [PB-1:0]      start_s1;
	logic [SB-1:0]      diff_s1 [MAX_PATTERN];

	// Stage 1 logic
	logic               fire;
	logic               is_load;
	logic               is_text;
	logic [SB-1:0]      sym;
	logic [LW-1:0]      plen_base;
	logic               has_room;
	logic [LW-1:0]      plen_load;
	logic [LW-1:0]      fill_inc;
	logic [PB-1:0]      tpos_inc;
	logic [SB-1:0]      win_new [MAX_PATTERN];
	logic [SB-1:0]      diff [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] lane_ok;
	status_t            status_d;

	// Stage 2 logic
	logic [SUMW-1:0]    node [2*NL-1];
	logic [SUMW-1:0]    sum;
	logic               found;

	// Issue only when the result queue has room for both the beat in flight and the new beat
	assign fire    = cmd_avail &&
		((CW+1)'(res_count) + (CW+1)'(valid_s1) < (CW+1)'(RES_DEPTH));
	assign cmd_deq = fire;

	// Decode and next-state terms
	always_comb begin
		sym       = SB'(cmd_head.sym);
		is_load   = (cmd_head.kind == CMD_LOAD);
		is_text   = (cmd_head.kind == CMD_TEXT) && ready_q;
		plen_base = ready_q ? '0 : plen_q;
		has_room  = (plen_base < LW'(MAX_PATTERN));
		plen_load = has_room ? plen_base + LW'(1) : plen_base;
		fill_inc  = (fill_q < plen_q) ? fill_q + LW'(1) : fill_q;
		tpos_inc  = (tpos_q == '1) ? tpos_q : tpos_q + PB'(1);
		if (is_load) begin
			status_d = has_room ? ST_OK : ST_TOO_LONG;
		end else if (!ready_q) begin
			status_d = ST_NO_PATTERN;
		end else begin
			status_d = ST_OK;
		end
	end

	// Per-lane differences against the shifted window
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			win_new[j] = (j == 0) ? sym : win_q[(j == 0) ? 0 : j - 1];
			if (LW'(j) < plen_q) begin
				diff[j] = (pat_q[j] > win_new[j]) ? pat_q[j] - win_new[j]
				                                  : win_new[j] - pat_q[j];
			end else begin
				diff[j] = '0;
			end
			lane_ok[j] = (DW'(diff[j]) <= DW'(delta_q));
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_q    <= '0;
			gamma_q    <= '0;
			gamma_en_q <= 1'b0;
		end else if (cfg_wr.wr_en) begin
			case (cfg_wr.index)
				REG_DELTA:    delta_q    <= cfg_wr.data[DELTA_W-1:0];
				REG_GAMMA:    gamma_q    <= cfg_wr.data[SUM_W-1:0];
				REG_GAMMA_EN: gamma_en_q <= cfg_wr.data[0];
				default: ;
			endcase
		end
	end

	// Control state of the execution stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q   <= '0;
			ready_q  <= 1'b0;
			tpos_q   <= '0;
			fill_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= fire;
			if (fire) begin
				case (cmd_head.kind)
					CMD_LOAD: begin
						plen_q  <= plen_load;
						ready_q <= cmd_head.last && (plen_load != '0);
						if (ready_q) begin
							tpos_q <= '0;
							fill_q <= '0;
						end
					end
					CMD_TEXT: begin
						if (ready_q) begin
							fill_q <= cmd_head.last ? '0 : fill_inc;
							tpos_q <= cmd_head.last ? '0 : tpos_inc;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Shift lines and stage 1 payload
	always_ff @(posedge clk) begin
		if (fire && is_load && has_room) begin
			for (int j = 0; j < MAX_PATTERN; j++) begin
				pat_q[j] <= (j == 0) ? sym : pat_q[(j == 0) ? 0 : j - 1];
			end
		end
		if (fire && is_text) begin
			for (int j = 0; j < MAX_PATTERN; j++) begin
				win_q[j] <= win_new[j];
			end
		end
		if (fire) begin
			load_s1   <= is_load;
			text_s1   <= is_text;
			status_s1 <= status_d;
			check_s1  <= (fill_inc == plen_q);
			dok_s1    <= &lane_ok;
			last_s1   <= cmd_head.last;
			start_s1  <= tpos_q - (PB'(plen_q) - PB'(1));
			for (int j = 0; j < MAX_PATTERN; j++) begin
				diff_s1[j] <= diff[j];
			end
		end
	end

	// Stage 2: adder tree over the lane differences
	genvar g;
	generate
		for (g = 0; g < NL; g++) begin : g_leaf
			if (g < MAX_PATTERN) begin : g_used
				assign node[NL-1+g] = SUMW'(diff_s1[g]);
			end else begin : g_pad
				assign node[NL-1+g] = '0;
			end
		end
		for (g = 0; g < NL - 1; g++) begin : g_node
			assign node[g] = node[2*g+1] + node[2*g+2];
		end
	endgenerate

	assign sum = node[0];

	// Limit checks and result beat
	always_comb begin
		found = text_s1 && check_s1 && dok_s1 &&
			(!gamma_en_q || (GW'(sum) <= GW'(gamma_q)));
		res_push        = valid_s1;
		res_data.found  = found;
		res_data.start  = found ? START_W'(start_s1[SW-1:0]) : '0;
		res_data.sum    = '0;
		if (found) begin
			res_data.sum = (GW'(sum) > GW'(SUM_MAX)) ? SUM_MAX : SUM_W'(GW'(sum));
		end
		res_data.none   = text_s1 && last_s1 && !(any_q || found);
		res_data.status = status_s1;
	end

	// Match-seen flag, kept in beat order at stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
		end else if (valid_s1) begin
			if (load_s1) begin
				any_q <= 1'b0;
			end else if (text_s1) begin
				any_q <= last_s1 ? 1'b0 : (any_q || found);
			end
		end
	end

endmodule

// ===== design/dgpm_rq.sv =====
// ----------------------------------------------------------------------------
// dgpm_rq - result queue of the pattern matcher
// Holds finished result beats until the consumer pops them.
// ----------------------------------------------------------------------------
module dgpm_rq import dgpm_pkg::*; (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  result_t                         wr_data,
	input  logic                            rd_en,
	output logic                            empty,
	output result_t                         head,
	output logic [$clog2(RES_DEPTH+1)-1:0]  count
);

	localparam int PW = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
	localparam int CW = $clog2(RES_DEPTH + 1);

	result_t        mem_q [RES_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           pop_ok;

	assign empty  = (cnt_q == '0);
	assign pop_ok = rd_en && !empty;
	assign head   = mem_q[rd_ptr_q];
	assign count  = cnt_q;

	// Storage; the writer never pushes into a full queue
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (wr_en && !pop_ok) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop_ok && !wr_en) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== design/delta_gamma_pattern_matcher_top.sv =====
// ----------------------------------------------------------------------------
// delta_gamma_pattern_matcher_top - delta-gamma approximate pattern matcher
// Loads a pattern, then checks every text window against it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (push/full): each beat is a pattern symbol (cmd 0) or a
//   text symbol (cmd 1); last closes the pattern or the text.
//   Result channel (empty/pop): one result beat for every input beat, in
//   order: match flag, window start, difference sum, none_found, status.
//   Register port: cfg_wr_en/cfg_index/cfg_data write delta, gamma and the
//   gamma enable; write them only while the block is idle.
// Timing:
//   One beat per cycle sustained while the result queue has room. A beat
//   passes through the command queue and the execute-stage registers; the
//   adder tree and limit check then write it into the result queue.
//   The rate is set by the window compare and the adder tree, one beat each.
// Reset clears the registers, pattern length, text position and both queues.
// When the consumer stops popping, the 4-entry result queue fills, the
// execute stage stops, then the 4-entry command queue fills and full rises.
// ----------------------------------------------------------------------------
module delta_gamma_pattern_matcher_top import dgpm_pkg::*; #(
	parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
	parameter int SYMBOL_BITS   = SYMBOL_BITS_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  cmd,
	input  logic [SYM_IN_W-1:0]   symbol_value,
	input  logic                  last,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  empty,
	input  logic                  pop,
	output logic                  match_found,
	output logic [START_W-1:0]    match_start,
	output logic [SUM_W-1:0]      distance_sum,
	output logic                  none_found,
	output logic [1:0]            status
);

	cmd_t                          cmd_head;
	logic                          cmd_avail;
	logic                          cmd_deq;
	cfg_wr_t                       cfg_wr;
	logic                          res_push;
	result_t                       res_data;
	result_t                       res_head;
	logic [$clog2(RES_DEPTH+1)-1:0] res_count;

	assign cfg_wr.wr_en = cfg_wr_en;
	assign cfg_wr.index = cfg_reg_t'(cfg_index);
	assign cfg_wr.data  = cfg_data;

	// Input side and command queue
	dgpm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.cmd          (cmd),
		.symbol_value (symbol_value),
		.last         (last),
		.full         (full),
		.deq          (cmd_deq),
		.avail        (cmd_avail),
		.head         (cmd_head)
	);

	// Execution side
	dgpm_back #(
		.MAX_PATTERN   (MAX_PATTERN),
		.SYMBOL_BITS   (SYMBOL_BITS),
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cmd_avail (cmd_avail),
		.cmd_head  (cmd_head),
		.cmd_deq   (cmd_deq),
		.res_count (res_count),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	// Result queue
	dgpm_rq u_rq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_data),
		.rd_en   (pop),
		.empty   (empty),
		.head    (res_head),
		.count   (res_count)
	);

	assign match_found  = res_head.found;
	assign match_start  = res_head.start;
	assign distance_sum = res_head.sum;
	assign none_found   = res_head.none;
	assign status       = res_head.status;

endmodule
